[hw/rtl/ipds_pkg.sv]
`timescale 1ns / 1ps

package ipds_pkg;

   localparam int unsigned TICK_MICROSECONDS = 1000;

   localparam int PEAK_W   = 16;
   localparam int WEIGHT_W = 10;
   localparam int AMP_W    = 20;
   localparam int TIME_W   = 26;
   localparam int POS_W    = 27;
   localparam int PROD_W   = PEAK_W + WEIGHT_W;
   localparam int AMP_LSB  = 6;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   localparam int REQ_DEPTH = 4;
   localparam int REQ_PTR_W = $clog2(REQ_DEPTH);
   localparam int RSP_DEPTH = 2;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_FAST   = 2'd1,
      OP_SLOW   = 2'd2,
      OP_MILLI  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      REG_COIL1_WEIGHT       = 3'd0,
      REG_COIL2_WEIGHT       = 3'd1,
      REG_COIL1_DETECT_LEVEL = 3'd2,
      REG_COIL2_DETECT_LEVEL = 3'd3,
      REG_COIL1_STOP_LEVEL   = 3'd4,
      REG_PAUSE_LIMIT_US     = 3'd5,
      REG_TRANSMIT_LIMIT_US  = 3'd6,
      REG_START_POSITION     = 3'd7
   } reg_index_type;

   localparam logic [2:0] MODE_SLEEP    = 3'd0;
   localparam logic [2:0] MODE_STANDBY  = 3'd1;
   localparam logic [2:0] MODE_DETECT   = 3'd2;
   localparam logic [2:0] MODE_PAUSE    = 3'd3;
   localparam logic [2:0] MODE_TRANSMIT = 3'd4;
   localparam logic [2:0] MODE_SHORT    = 3'd5;
   localparam logic [2:0] MODE_RECT     = 3'd6;
   localparam logic [2:0] MODE_STOP     = 3'd7;

   localparam logic [1:0] TX_ACT_NONE        = 2'd0;
   localparam logic [1:0] TX_ACT_SHORT_START = 2'd1;
   localparam logic [1:0] TX_ACT_TX_START    = 2'd2;
   localparam logic [1:0] TX_ACT_STOP        = 2'd3;

   localparam logic [1:0] RX_ACT_NONE    = 2'd0;
   localparam logic [1:0] RX_ACT_START   = 2'd1;
   localparam logic [1:0] RX_ACT_RECTIFY = 2'd2;
   localparam logic [1:0] RX_ACT_STOP    = 2'd3;

   typedef struct packed {
      logic sample;
      logic fast;
      logic slow;
      logic milli;
   } op_class_type;

   typedef struct packed {
      op_class_type      cls;
      logic [PEAK_W-1:0] coil1_peak;
      logic [PEAK_W-1:0] coil2_peak;
      logic [POS_W-1:0]  encoder_position;
   } req_item_type;

   typedef struct packed {
      logic         valid;
      req_item_type item;
   } req_slot_type;

   typedef struct packed {
      logic [2:0]       tx_mode;
      logic [2:0]       rx_mode;
      logic [1:0]       tx_action;
      logic [1:0]       rx_action;
      logic [AMP_W-1:0] coil1_amplitude;
      logic [AMP_W-1:0] coil2_amplitude;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } rsp_slot_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0] coil1_weight;
      logic [WEIGHT_W-1:0] coil2_weight;
      logic [AMP_W-1:0]    coil1_detect_level;
      logic [AMP_W-1:0]    coil2_detect_level;
      logic [AMP_W-1:0]    coil1_stop_level;
      logic [TIME_W-1:0]   pause_limit_us;
      logic [TIME_W-1:0]   transmit_limit_us;
      logic [POS_W-1:0]    start_position;
   } cfg_type;

endpackage

[hw/rtl/ipds_csr.sv]
`timescale 1ns / 1ps

module ipds_csr import ipds_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_idx;
   logic          wr_en;

   assign reg_idx = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_COIL1_WEIGHT:       cfg_in.coil1_weight       = pwdata[WEIGHT_W-1:0];
            REG_COIL2_WEIGHT:       cfg_in.coil2_weight       = pwdata[WEIGHT_W-1:0];
            REG_COIL1_DETECT_LEVEL: cfg_in.coil1_detect_level = pwdata[AMP_W-1:0];
            REG_COIL2_DETECT_LEVEL: cfg_in.coil2_detect_level = pwdata[AMP_W-1:0];
            REG_COIL1_STOP_LEVEL:   cfg_in.coil1_stop_level   = pwdata[AMP_W-1:0];
            REG_PAUSE_LIMIT_US:     cfg_in.pause_limit_us     = pwdata[TIME_W-1:0];
            REG_TRANSMIT_LIMIT_US:  cfg_in.transmit_limit_us  = pwdata[TIME_W-1:0];
            REG_START_POSITION:     cfg_in.start_position     = pwdata[POS_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_COIL1_WEIGHT:       prdata = CSR_DATA_W'(cfg_ff.coil1_weight);
         REG_COIL2_WEIGHT:       prdata = CSR_DATA_W'(cfg_ff.coil2_weight);
         REG_COIL1_DETECT_LEVEL: prdata = CSR_DATA_W'(cfg_ff.coil1_detect_level);
         REG_COIL2_DETECT_LEVEL: prdata = CSR_DATA_W'(cfg_ff.coil2_detect_level);
         REG_COIL1_STOP_LEVEL:   prdata = CSR_DATA_W'(cfg_ff.coil1_stop_level);
         REG_PAUSE_LIMIT_US:     prdata = CSR_DATA_W'(cfg_ff.pause_limit_us);
         REG_TRANSMIT_LIMIT_US:  prdata = CSR_DATA_W'(cfg_ff.transmit_limit_us);
         REG_START_POSITION:     prdata = CSR_DATA_W'(cfg_ff.start_position);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coil1_weight       <= WEIGHT_W'(282);
         cfg_ff.coil2_weight       <= WEIGHT_W'(282);
         cfg_ff.coil1_detect_level <= AMP_W'(768);
         cfg_ff.coil2_detect_level <= AMP_W'(1280);
         cfg_ff.coil1_stop_level   <= AMP_W'(2560);
         cfg_ff.pause_limit_us     <= TIME_W'(500000);
         cfg_ff.transmit_limit_us  <= TIME_W'(1000000);
         cfg_ff.start_position     <= POS_W'(60000);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hw/rtl/ipds_front.sv]
`timescale 1ns / 1ps

module ipds_front import ipds_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [1:0]        req_operation,
   input  logic [PEAK_W-1:0] req_coil1_peak,
   input  logic [PEAK_W-1:0] req_coil2_peak,
   input  logic [POS_W-1:0]  req_encoder_position,
   input  logic              take,
   output req_slot_type      head
);

   req_item_type            slots_ff [REQ_DEPTH];
   logic [REQ_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [REQ_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [REQ_PTR_W:0]      count_ff, count_in;
   req_item_type            in_item;
   logic                    push_ok;
   logic                    pop_ok;

   always_comb begin
      in_item.cls              = '0;
      in_item.coil1_peak       = req_coil1_peak;
      in_item.coil2_peak       = req_coil2_peak;
      in_item.encoder_position = req_encoder_position;
      unique case (op_type'(req_operation))
         OP_SAMPLE: in_item.cls.sample = 1'b1;
         OP_FAST:   in_item.cls.fast   = 1'b1;
         OP_SLOW:   in_item.cls.slow   = 1'b1;
         OP_MILLI:  in_item.cls.milli  = 1'b1;
      endcase
   end

   assign full      = (count_ff == (REQ_PTR_W+1)'(REQ_DEPTH));
   assign push_ok   = push && !full;
   assign pop_ok    = take && head.valid;

   always_comb begin
      head.valid = (count_ff != '0);
      head.item  = slots_ff[rd_ptr_ff];
   end

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + REQ_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + REQ_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (REQ_PTR_W+1)'(push_ok) - (REQ_PTR_W+1)'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slots_ff[wr_ptr_ff] <= in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hw/rtl/ipds_back.sv]
`timescale 1ns / 1ps

module ipds_back import ipds_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  req_slot_type head,
   output logic         take,
   input  logic         rsp_ready,
   output rsp_slot_type rsp_write
);

   logic [2:0]        tx_mode_ff, tx_mode_in;
   logic [2:0]        rx_mode_ff, rx_mode_in;
   logic [TIME_W-1:0] pause_ff, pause_in;
   logic [TIME_W-1:0] transmit_ff, transmit_in;
   logic [AMP_W-1:0]  amp1_ff, amp1_in;
   logic [AMP_W-1:0]  amp2_ff, amp2_in;
   logic [1:0]        tx_act;
   logic [1:0]        rx_act;
   logic [PROD_W-1:0] prod1;
   logic [PROD_W-1:0] prod2;
   logic [TIME_W:0]   pause_sum;
   logic [TIME_W:0]   transmit_sum;
   logic              fire;
   req_item_type      item;

   assign item = head.item;
   assign fire = head.valid && rsp_ready;
   assign take = fire;

   assign prod1 = PROD_W'(item.coil1_peak) * PROD_W'(cfg.coil1_weight);
   assign prod2 = PROD_W'(item.coil2_peak) * PROD_W'(cfg.coil2_weight);

   assign pause_sum    = {1'b0, pause_ff} + (TIME_W+1)'(TICK_MICROSECONDS);
   assign transmit_sum = {1'b0, transmit_ff} + (TIME_W+1)'(TICK_MICROSECONDS);

   always_comb begin
      tx_mode_in  = tx_mode_ff;
      rx_mode_in  = rx_mode_ff;
      pause_in    = pause_ff;
      transmit_in = transmit_ff;
      amp1_in     = amp1_ff;
      amp2_in     = amp2_ff;
      tx_act      = TX_ACT_NONE;
      rx_act      = RX_ACT_NONE;
      if (fire) begin
         if (item.cls.sample) begin
            // The 16 by 10 bit product shifted down by six never exceeds 20 bits.
            amp1_in = prod1[PROD_W-1:AMP_LSB];
            amp2_in = prod2[PROD_W-1:AMP_LSB];
         end else if (item.cls.fast) begin
            case (tx_mode_ff)
               MODE_SHORT: begin
                  if (amp1_ff > cfg.coil1_detect_level) begin
                     tx_mode_in = MODE_PAUSE;
                  end
               end
               MODE_PAUSE: begin
                  if (pause_ff > cfg.pause_limit_us) begin
                     tx_mode_in = MODE_TRANSMIT;
                     tx_act     = TX_ACT_TX_START;
                  end
               end
               MODE_TRANSMIT: begin
                  if (amp1_ff > cfg.coil1_stop_level &&
                      transmit_ff > cfg.transmit_limit_us) begin
                     tx_mode_in = MODE_STOP;
                     tx_act     = TX_ACT_STOP;
                  end
               end
               default: begin
               end
            endcase
            if (rx_mode_ff == MODE_DETECT && amp2_ff > cfg.coil2_detect_level) begin
               rx_mode_in = MODE_STANDBY;
               rx_act     = RX_ACT_STOP;
            end
         end else if (item.cls.slow) begin
            if (rx_mode_ff == MODE_STANDBY) begin
               tx_mode_in = MODE_SHORT;
               rx_mode_in = MODE_DETECT;
               tx_act     = TX_ACT_SHORT_START;
               rx_act     = RX_ACT_START;
            end else if (rx_mode_ff == MODE_DETECT) begin
               rx_mode_in = MODE_RECT;
               rx_act     = RX_ACT_RECTIFY;
            end
         end else if (item.cls.milli) begin
            if (tx_mode_ff == MODE_PAUSE) begin
               pause_in = pause_sum[TIME_W] ? TIME_MAX : pause_sum[TIME_W-1:0];
            end else if (tx_mode_ff == MODE_TRANSMIT) begin
               transmit_in = transmit_sum[TIME_W] ? TIME_MAX : transmit_sum[TIME_W-1:0];
            end
            if (item.encoder_position > cfg.start_position && rx_mode_ff == MODE_SLEEP) begin
               rx_mode_in = MODE_STANDBY;
            end
         end
      end
   end

   always_comb begin
      rsp_write.valid                = fire;
      rsp_write.item.tx_mode         = tx_mode_in;
      rsp_write.item.rx_mode         = rx_mode_in;
      rsp_write.item.tx_action       = tx_act;
      rsp_write.item.rx_action       = rx_act;
      rsp_write.item.coil1_amplitude = amp1_in;
      rsp_write.item.coil2_amplitude = amp2_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_mode_ff  <= MODE_SLEEP;
         rx_mode_ff  <= MODE_SLEEP;
         pause_ff    <= '0;
         transmit_ff <= '0;
         amp1_ff     <= '0;
         amp2_ff     <= '0;
      end else begin
         tx_mode_ff  <= tx_mode_in;
         rx_mode_ff  <= rx_mode_in;
         pause_ff    <= pause_in;
         transmit_ff <= transmit_in;
         amp1_ff     <= amp1_in;
         amp2_ff     <= amp2_in;
      end
   end

endmodule

[hw/rtl/ipds_rsp_queue.sv]
`timescale 1ns / 1ps

module ipds_rsp_queue import ipds_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  rsp_slot_type wr,
   output logic         ready,
   input  logic         pop,
   output logic         empty,
   output rsp_item_type head
);

   rsp_item_type         slots_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_PTR_W:0]   count_ff, count_in;
   logic                 pop_ok;
   logic                 push_ok;

   assign empty   = (count_ff == '0);
   assign pop_ok  = pop && !empty;
   assign ready   = (count_ff != (RSP_PTR_W+1)'(RSP_DEPTH)) || pop_ok;
   assign push_ok = wr.valid && ready;
   assign head    = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + RSP_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (RSP_PTR_W+1)'(push_ok) - (RSP_PTR_W+1)'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slots_ff[wr_ptr_ff] <= wr.item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hw/rtl/inverter_pulse_detect_sequencer_core.sv]
`timescale 1ns / 1ps
// An accepted item is registered in the request queue, settled by the engine, and its
// result is registered in the result queue, when neither queue is stalled.
// Throughput: one item per cycle unless stalled; every event settles in one engine pass.
// Reset clears both queues, the modes, time counters and amplitudes, and loads the
// register defaults.

module inverter_pulse_detect_sequencer_core import ipds_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [1:0]            req_operation,
   input  logic [PEAK_W-1:0]     req_coil1_peak,
   input  logic [PEAK_W-1:0]     req_coil2_peak,
   input  logic [POS_W-1:0]      req_encoder_position,
   output logic                  empty,
   input  logic                  pop,
   output logic [2:0]            rsp_tx_mode,
   output logic [2:0]            rsp_rx_mode,
   output logic [1:0]            rsp_tx_action,
   output logic [1:0]            rsp_rx_action,
   output logic [AMP_W-1:0]      rsp_coil1_amplitude,
   output logic [AMP_W-1:0]      rsp_coil2_amplitude,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type      cfg;
   req_slot_type req_head;
   logic         take;
   logic         rsp_ready;
   rsp_slot_type rsp_write;
   rsp_item_type rsp_head;

   ipds_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ipds_front u_front (
      .clock                (clock),
      .reset                (reset),
      .push                 (push),
      .full                 (full),
      .req_operation        (req_operation),
      .req_coil1_peak       (req_coil1_peak),
      .req_coil2_peak       (req_coil2_peak),
      .req_encoder_position (req_encoder_position),
      .take                 (take),
      .head                 (req_head)
   );

   ipds_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .head      (req_head),
      .take      (take),
      .rsp_ready (rsp_ready),
      .rsp_write (rsp_write)
   );

   ipds_rsp_queue u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .wr    (rsp_write),
      .ready (rsp_ready),
      .pop   (pop),
      .empty (empty),
      .head  (rsp_head)
   );

   assign rsp_tx_mode         = rsp_head.tx_mode;
   assign rsp_rx_mode         = rsp_head.rx_mode;
   assign rsp_tx_action       = rsp_head.tx_action;
   assign rsp_rx_action       = rsp_head.rx_action;
   assign rsp_coil1_amplitude = rsp_head.coil1_amplitude;
   assign rsp_coil2_amplitude = rsp_head.coil2_amplitude;

`ifndef SYNTHESIS
   a_short_start_pairs: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_tx_action == TX_ACT_SHORT_START) |->
      (rsp_tx_mode == MODE_SHORT && rsp_rx_mode == MODE_DETECT &&
       rsp_rx_action == RX_ACT_START))
      else $error("Short start reported without the matching receiver start.");

   a_stop_mode: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_tx_action == TX_ACT_STOP) |-> (rsp_tx_mode == MODE_STOP))
      else $error("Transmitter stop reported outside stop mode.");

   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      (rsp_write.valid && empty) |=> !empty)
      else $error("A finished item did not reach the result queue.");
`endif

endmodule
